>>> sv/mhpq_pkg.sv
package mhpq_pkg;

  // Default sizing
  localparam int CAPACITY_DEF    = 1024;
  localparam int VALUE_WIDTH_DEF = 32;

  // Beat layout
  localparam int OP_W        = 2;
  localparam int IN_VAL_W    = 32;
  localparam int IN_TDATA_W  = 32;
  localparam int TOP_W       = 32;
  localparam int TOTAL_W     = 11;
  localparam int OUT_FIELD_W = TOP_W + TOTAL_W + 3;
  localparam int OUT_TDATA_W = ((OUT_FIELD_W + 7) / 8) * 8;

  // Opcodes
  localparam logic [OP_W-1:0] OP_PUSH  = 2'd0;
  localparam logic [OP_W-1:0] OP_POP   = 2'd1;
  localparam logic [OP_W-1:0] OP_CLEAR = 2'd2;

endpackage

>>> sv/mhpq_mem.sv
module mhpq_mem #(
  parameter int DEPTH = 1024,
  parameter int AW    = 10,
  parameter int DW    = 32
) (
  input  logic                 clk,
  input  logic                 wr_en,
  input  logic [AW-1:0]        wr_addr,
  input  logic signed [DW-1:0] wr_data,
  input  logic [AW-1:0]        rd_addr_a,
  input  logic [AW-1:0]        rd_addr_b,
  output logic signed [DW-1:0] rd_data_a_r,
  output logic signed [DW-1:0] rd_data_b_r
);

  logic signed [DW-1:0] mem [DEPTH];

  // One write port, two registered read ports
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_a_r <= mem[rd_addr_a];
    rd_data_b_r <= mem[rd_addr_b];
  end

endmodule

>>> sv/max_heap_priority_queue.sv
// Binary max-heap priority queue, one operation per input beat, one result beat each.
// Push sifts up and pop sifts down, one tree level per RAM read/compare pair, then the
// root is read back for the result beat; clear, error and no-op go straight to that read.
// A new beat is accepted only once the result of the last one is registered, even if that
// result still waits at the output.
// Reset (rst_n low, synchronous) empties the heap; RAM contents are not cleared.
module max_heap_priority_queue #(
  parameter int CAPACITY    = mhpq_pkg::CAPACITY_DEF,
  parameter int VALUE_WIDTH = mhpq_pkg::VALUE_WIDTH_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  input  logic [mhpq_pkg::IN_TDATA_W-1:0]  in_tdata,   // [31:0] value
  input  logic [mhpq_pkg::OP_W-1:0]        in_tuser,   // [1:0] opcode
  output logic                             out_tvalid,
  input  logic                             out_tready,
  // [31:0] top_value, [42:32] entry_total, [43] is_empty, [44] is_full, [45] op_error
  output logic [mhpq_pkg::OUT_TDATA_W-1:0] out_tdata
);

  import mhpq_pkg::*;

  localparam int AW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int IW = AW + 2;

  localparam logic [2:0] S_IDLE    = 3'd0;
  localparam logic [2:0] S_UP_RD   = 3'd1;
  localparam logic [2:0] S_UP_CMP  = 3'd2;
  localparam logic [2:0] S_DN_LOAD = 3'd3;
  localparam logic [2:0] S_DN_RD   = 3'd4;
  localparam logic [2:0] S_DN_CMP  = 3'd5;
  localparam logic [2:0] S_TOP_RD  = 3'd6;
  localparam logic [2:0] S_TOP_CAP = 3'd7;

  logic [2:0]                    state_r, state_nxt;
  logic [CW-1:0]                 cnt_r, cnt_nxt;
  logic [AW-1:0]                 pos_r, pos_nxt;
  logic signed [VALUE_WIDTH-1:0] v_r, v_nxt;
  logic                          err_r, err_nxt;
  logic                          out_valid_r, out_valid_nxt;
  logic [OUT_TDATA_W-1:0]        out_data_r, out_data_nxt;

  logic                          wr_en;
  logic [AW-1:0]                 wr_addr;
  logic signed [VALUE_WIDTH-1:0] wr_data;
  logic [AW-1:0]                 rd_addr_a, rd_addr_b;
  logic signed [VALUE_WIDTH-1:0] rd_data_a, rd_data_b;

  logic                          in_fire;
  logic [OP_W-1:0]               op;
  logic signed [VALUE_WIDTH-1:0] key_in;
  logic                          is_full, is_empty;
  logic [CW-1:0]                 cnt_dec;
  logic [AW-1:0]                 pos_dec, parent;
  logic [IW-1:0]                 child_l, child_r, cnt_ext;
  logic                          l_ok, r_ok, pick_r;
  logic signed [VALUE_WIDTH-1:0] child_val;
  logic [IW-1:0]                 child_idx;
  logic signed [TOP_W-1:0]       top_val;

  mhpq_mem #(
    .DEPTH (CAPACITY),
    .AW    (AW),
    .DW    (VALUE_WIDTH)
  ) u_mem (
    .clk         (clk),
    .wr_en       (wr_en),
    .wr_addr     (wr_addr),
    .wr_data     (wr_data),
    .rd_addr_a   (rd_addr_a),
    .rd_addr_b   (rd_addr_b),
    .rd_data_a_r (rd_data_a),
    .rd_data_b_r (rd_data_b)
  );

  // Handshake and input decode
  assign in_tready = (state_r == S_IDLE);
  assign in_fire   = in_tvalid && in_tready;
  assign op        = in_tuser;
  assign key_in    = VALUE_WIDTH'($signed(in_tdata[IN_VAL_W-1:0]));

  // Count status
  assign is_full  = (cnt_r == CW'(CAPACITY));
  assign is_empty = (cnt_r == '0);
  assign cnt_dec  = cnt_r - CW'(1);
  assign cnt_ext  = IW'(cnt_r);

  // Tree index arithmetic
  assign pos_dec = pos_r - AW'(1);
  assign parent  = pos_dec >> 1;
  assign child_l = {1'b0, pos_r, 1'b1};
  assign child_r = child_l + IW'(1);
  assign l_ok    = (child_l < cnt_ext);
  assign r_ok    = (child_r < cnt_ext);

  // Larger child; right only when strictly larger
  assign pick_r    = r_ok && (rd_data_b > rd_data_a);
  assign child_val = pick_r ? rd_data_b : rd_data_a;
  assign child_idx = pick_r ? child_r : child_l;

  assign top_val = is_empty ? '0 : TOP_W'(rd_data_a);

  // Read address select
  always_comb begin
    case (state_r)
      S_IDLE:               rd_addr_a = cnt_dec[AW-1:0];
      S_UP_RD:              rd_addr_a = parent;
      S_DN_RD:              rd_addr_a = child_l[AW-1:0];
      S_TOP_RD, S_TOP_CAP:  rd_addr_a = '0;
      default:              rd_addr_a = '0;
    endcase
  end
  assign rd_addr_b = child_r[AW-1:0];

  // Sequencer
  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    pos_nxt       = pos_r;
    v_nxt         = v_r;
    err_nxt       = err_r;
    out_data_nxt  = out_data_r;
    out_valid_nxt = out_valid_r && !out_tready;
    wr_en         = 1'b0;
    wr_addr       = pos_r;
    wr_data       = v_r;

    case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          err_nxt   = 1'b0;
          state_nxt = S_TOP_RD;
          case (op)
            OP_PUSH: begin
              if (is_full) begin
                err_nxt = 1'b1;
              end else begin
                pos_nxt   = cnt_r[AW-1:0];
                v_nxt     = key_in;
                cnt_nxt   = cnt_r + CW'(1);
                state_nxt = S_UP_RD;
              end
            end
            OP_POP: begin
              if (is_empty) begin
                err_nxt = 1'b1;
              end else begin
                cnt_nxt   = cnt_dec;
                state_nxt = S_DN_LOAD;
              end
            end
            OP_CLEAR: begin
              cnt_nxt = '0;
            end
            default: begin
              cnt_nxt = cnt_r;
            end
          endcase
        end
      end

      // Sift up: move parents down until the new key settles
      S_UP_RD: begin
        if (pos_r == '0) begin
          wr_en     = 1'b1;
          state_nxt = S_TOP_RD;
        end else begin
          state_nxt = S_UP_CMP;
        end
      end
      S_UP_CMP: begin
        wr_en = 1'b1;
        if (v_r > rd_data_a) begin
          wr_data   = rd_data_a;
          pos_nxt   = parent;
          state_nxt = S_UP_RD;
        end else begin
          state_nxt = S_TOP_RD;
        end
      end

      // Sift down: last entry goes to the root, larger children move up
      S_DN_LOAD: begin
        v_nxt     = rd_data_a;
        pos_nxt   = '0;
        state_nxt = S_DN_RD;
      end
      S_DN_RD: begin
        if (!l_ok) begin
          wr_en     = 1'b1;
          state_nxt = S_TOP_RD;
        end else begin
          state_nxt = S_DN_CMP;
        end
      end
      S_DN_CMP: begin
        wr_en = 1'b1;
        if (child_val > v_r) begin
          wr_data   = child_val;
          pos_nxt   = child_idx[AW-1:0];
          state_nxt = S_DN_RD;
        end else begin
          state_nxt = S_TOP_RD;
        end
      end

      S_TOP_RD: begin
        state_nxt = S_TOP_CAP;
      end

      // Result beat once the output register is free
      S_TOP_CAP: begin
        if (!out_valid_r || out_tready) begin
          out_data_nxt  = OUT_TDATA_W'({err_r, is_full, is_empty,
                                        TOTAL_W'(cnt_r), top_val});
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
      err_r       <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
      err_r       <= err_nxt;
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    pos_r      <= pos_nxt;
    v_r        <= v_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

`ifndef SYNTHESIS
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CW'(CAPACITY))
    else $error("entry count above capacity");

  a_push_inc: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && op == OP_PUSH && !is_full) |=> cnt_r == CW'($past(cnt_r) + CW'(1)))
    else $error("push did not grow the count");

  a_up_root: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_UP_CMP) |-> pos_r != '0)
    else $error("sift up compared at the root");

  a_dn_child: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DN_CMP) |-> child_l < cnt_ext)
    else $error("sift down compared a missing child");
`endif

endmodule

>>> tb/max_heap_priority_queue_test.sv
module max_heap_priority_queue_test;
  import mhpq_pkg::*;

  // Opcode three is unused by the block: status only, no change
  localparam logic [OP_W-1:0] OP_NOP = 2'd3;

  localparam logic [31:0] VAL_MIN  = 32'h8000_0000;
  localparam logic [31:0] VAL_MAX  = 32'h7FFF_FFFF;
  localparam int          SETTLE_CYCLES = 30;

  typedef struct packed {
    logic signed [TOP_W-1:0]   top;
    logic        [TOTAL_W-1:0] total;
    logic                      empty;
    logic                      full;
    logic                      err;
  } heap_status_t;

  logic                   clk;
  logic                   rst_n      = 1'b0;
  logic                   in_tvalid  = 1'b0;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata   = '0;
  logic [OP_W-1:0]        in_tuser   = OP_PUSH;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;

  // Predicted heap contents and fill level
  logic signed [TOP_W-1:0] heap_keys [0:CAPACITY_DEF-1];
  int                      heap_fill = 0;

  heap_status_t expected_status_q [$];
  int           mismatch_count = 0;
  int           src_idle_pct   = 0;
  int           snk_idle_pct   = 0;

  max_heap_priority_queue DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  // Sink backpressure
  always @(negedge clk) begin
    out_tready <= ($urandom_range(99) >= snk_idle_pct);
  end

  // Heap model: apply one operation and return the status it should report
  function automatic heap_status_t heap_model_step(input logic [OP_W-1:0] op,
                                                   input logic signed [TOP_W-1:0] val);
    heap_status_t            st;
    int                      pos;
    int                      kid;
    int                      parent;
    logic signed [TOP_W-1:0] tmp;
    bit                      moving;
    st.err = 1'b0;
    case (op)
      OP_PUSH: begin
        if (heap_fill >= CAPACITY_DEF) begin
          st.err = 1'b1;
        end else begin
          pos = heap_fill;
          heap_keys[pos] = val;
          heap_fill++;
          moving = 1'b1;
          // sift up while strictly greater than the parent
          while (moving && pos > 0) begin
            parent = (pos - 1) / 2;
            if (heap_keys[pos] > heap_keys[parent]) begin
              tmp = heap_keys[pos];
              heap_keys[pos] = heap_keys[parent];
              heap_keys[parent] = tmp;
              pos = parent;
            end else begin
              moving = 1'b0;
            end
          end
        end
      end
      OP_POP: begin
        if (heap_fill == 0) begin
          st.err = 1'b1;
        end else begin
          heap_fill--;
          heap_keys[0] = heap_keys[heap_fill];
          pos = 0;
          moving = 1'b1;
          // sift down; right child only when strictly larger than left
          while (moving && (2 * pos + 1) < heap_fill) begin
            kid = 2 * pos + 1;
            if (kid + 1 < heap_fill && heap_keys[kid + 1] > heap_keys[kid]) kid++;
            if (heap_keys[kid] > heap_keys[pos]) begin
              tmp = heap_keys[kid];
              heap_keys[kid] = heap_keys[pos];
              heap_keys[pos] = tmp;
              pos = kid;
            end else begin
              moving = 1'b0;
            end
          end
        end
      end
      OP_CLEAR: begin
        heap_fill = 0;
      end
      default: ;
    endcase
    st.top   = (heap_fill != 0) ? heap_keys[0] : '0;
    st.total = heap_fill[TOTAL_W-1:0];
    st.empty = (heap_fill == 0);
    st.full  = (heap_fill >= CAPACITY_DEF);
    return st;
  endfunction

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    $display("%0t: %s mismatch: got %0h, expected %0h", $time, what, got, want);
    mismatch_count++;
  endtask

  // Result checker
  always @(posedge clk) begin : result_check
    heap_status_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (expected_status_q.size() == 0) begin
        report_mismatch("unexpected result beat", out_tdata, '0);
      end else begin
        want = expected_status_q.pop_front();
        if (out_tdata[31:0] !== want.top)    report_mismatch("top_value", out_tdata[31:0], want.top);
        if (out_tdata[42:32] !== want.total) report_mismatch("entry_total", out_tdata[42:32], want.total);
        if (out_tdata[43] !== want.empty)    report_mismatch("is_empty", out_tdata[43], want.empty);
        if (out_tdata[44] !== want.full)     report_mismatch("is_full", out_tdata[44], want.full);
        if (out_tdata[45] !== want.err)      report_mismatch("op_error", out_tdata[45], want.err);
      end
    end
  end

  // Send one beat; called and returns at a falling edge, leaves tvalid high
  task automatic issue_op(input logic [OP_W-1:0] op, input logic [IN_TDATA_W-1:0] val);
    while ($urandom_range(99) < src_idle_pct) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= val;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    expected_status_q.push_back(heap_model_step(op, val));
    @(negedge clk);
  endtask

  // Hold off the sender until every result is back
  task automatic wait_results_drained();
    in_tvalid <= 1'b0;
    while (expected_status_q.size() != 0) @(negedge clk);
  endtask

  function automatic logic [31:0] pick_value();
    case ($urandom_range(7))
      0: begin
        case ($urandom_range(3))
          0:       return VAL_MIN;
          1:       return VAL_MAX;
          2:       return 32'h0;
          default: return 32'hFFFF_FFFF;
        endcase
      end
      // narrow range makes ties common
      1, 2:    return $urandom_range(16) - 8;
      default: return $urandom;
    endcase
  endfunction

  task automatic test_directed_ops();
    issue_op(OP_POP, $urandom);     // pop on empty
    issue_op(OP_NOP, $urandom);
    issue_op(OP_CLEAR, $urandom);
    issue_op(OP_PUSH, 32'h0);
    issue_op(OP_PUSH, VAL_MIN);
    issue_op(OP_PUSH, VAL_MAX);
    issue_op(OP_PUSH, 32'hFFFF_FFFF);
    issue_op(OP_PUSH, 32'h5555_5555);
    issue_op(OP_PUSH, 32'hAAAA_AAAA);
    issue_op(OP_PUSH, VAL_MAX);     // duplicate of the top
    issue_op(OP_NOP, $urandom);
    // drain all seven, then one pop too many
    repeat (8) issue_op(OP_POP, $urandom);
    issue_op(OP_PUSH, 32'd5);
    issue_op(OP_PUSH, 32'd5);
    issue_op(OP_CLEAR, $urandom);
    issue_op(OP_POP, $urandom);
    issue_op(OP_PUSH, VAL_MIN);
  endtask

  task automatic test_fill_to_capacity();
    int i;
    issue_op(OP_CLEAR, $urandom);
    // ascending first half drives every push to the root
    for (i = 0; i < CAPACITY_DEF; i++) begin
      if (i < CAPACITY_DEF / 2) issue_op(OP_PUSH, VAL_MIN + i * 32'h0040_0000);
      else                      issue_op(OP_PUSH, pick_value());
    end
    issue_op(OP_PUSH, VAL_MAX);     // push on full
    issue_op(OP_PUSH, pick_value());
    issue_op(OP_NOP, $urandom);
    repeat (3) issue_op(OP_POP, $urandom);
    repeat (4) issue_op(OP_PUSH, pick_value());
    repeat (20) issue_op(OP_POP, $urandom);
    issue_op(OP_CLEAR, $urandom);
  endtask

  // Bursts of push-heavy, pop-heavy or mixed traffic
  task automatic test_random_traffic(input int beats);
    int                  sent;
    int                  burst;
    int                  mode;
    int                  pick;
    logic [OP_W-1:0]     op;
    sent = 0;
    while (sent < beats) begin
      mode  = $urandom_range(2);
      burst = $urandom_range(40, 5);
      while (burst > 0 && sent < beats) begin
        pick = $urandom_range(99);
        if (pick < 2)      op = OP_CLEAR;
        else if (pick < 4) op = OP_NOP;
        else begin
          pick = $urandom_range(99);
          case (mode)
            0:       op = (pick < 80) ? OP_PUSH : OP_POP;
            1:       op = (pick < 80) ? OP_POP : OP_PUSH;
            default: op = (pick < 50) ? OP_PUSH : OP_POP;
          endcase
        end
        issue_op(op, (op == OP_PUSH) ? pick_value() : $urandom);
        burst--;
        sent++;
      end
    end
  endtask

  initial begin
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    src_idle_pct = 14;
    snk_idle_pct = 53;
    test_directed_ops();
    wait_results_drained();
    test_random_traffic(20);

    src_idle_pct = 53;
    snk_idle_pct = 14;
    test_random_traffic(20);

    src_idle_pct = 0;
    snk_idle_pct = 0;
    test_fill_to_capacity();

    in_tvalid <= 1'b0;
    while (expected_status_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);

    if (mismatch_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #10_000_000;
    $display("TEST FAILED");
    $finish;
  end

endmodule
